FILE: rtl/bibt_pkg.sv
// ----------------------------------------------------------------------------
// bibt_pkg
// Shared constants, codes and direction tables of the boundary tracer.
// ----------------------------------------------------------------------------
package bibt_pkg;

    localparam int IMG_ROWS_DEF    = 60;
    localparam int IMG_COLS_DEF    = 80;
    localparam int POINT_DEPTH_DEF = 256;

    // Register reset values
    localparam logic [5:0] ROW_FLOOR_RST = 6'd15;
    localparam logic [7:0] MAX_POINTS_RST = 8'd200;
    localparam logic [7:0] EDGE_MIN_RST   = 8'd10;

    // Width of the per-trace mark kept in the visited memory.
    localparam int EPOCH_W = 4;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_TRACE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_ROW_FLOOR  = 2'd0,
        REG_MAX_POINTS = 2'd1,
        REG_EDGE_MIN   = 2'd2,
        REG_NONE       = 2'd3
    } reg_index_t;

    // Row step of each direction code.
    function automatic logic signed [7:0] step_row(input logic [2:0] dir);
        logic signed [7:0] s;
        case (dir)
            3'd1, 3'd2, 3'd3: s = -8'sd1;
            3'd5, 3'd6, 3'd7: s = 8'sd1;
            default:          s = 8'sd0;
        endcase
        return s;
    endfunction

    // Column step of each direction code.
    function automatic logic signed [7:0] step_col(input logic [2:0] dir);
        logic signed [7:0] s;
        case (dir)
            3'd0, 3'd1, 3'd7: s = 8'sd1;
            3'd3, 3'd4, 3'd5: s = -8'sd1;
            default:          s = 8'sd0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/bibt_ram.sv
// ----------------------------------------------------------------------------
// bibt_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bibt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/binary_image_boundary_tracer_top.sv
// ----------------------------------------------------------------------------
// binary_image_boundary_tracer_top
// Moore-neighbour boundary tracer over a binary image held in on-chip memory.
// ----------------------------------------------------------------------------
// A pixel load passes through the finishing step, and a point read through the
// read-data step and then the finishing step, before the result is offered. A
// trace runs a stop test for each point and scans its neighbours, each by an
// address step and then a memory data step; it ends on a stop test, a visited
// neighbour or a full neighbourhood scan, then a finishing step. Visited
// pixels are tagged with a trace number; after reset and on every fifteenth
// trace a clearing pass first writes all IMG_ROWS*IMG_COLS visited entries, one
// per cycle (4800 entries with the default image size). The neighbour address
// unit and the single read port of the pixel and visited memories set the
// per-slot rate. Input transfers are held off while an item is in progress; a
// finished result sits in the output register while the next item is taken.
module binary_image_boundary_tracer_top #(
    parameter int IMG_ROWS    = bibt_pkg::IMG_ROWS_DEF,
    parameter int IMG_COLS    = bibt_pkg::IMG_COLS_DEF,
    parameter int POINT_DEPTH = bibt_pkg::POINT_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [5:0] row,
    input  logic [6:0] col,
    input  logic       pixel,
    input  logic [7:0] index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] point_count,
    output logic       closed_loop,
    output logic [5:0] point_row,
    output logic [6:0] point_col
);

    localparam int PIX_DEPTH = IMG_ROWS * IMG_COLS;
    localparam int PAW       = $clog2(PIX_DEPTH);
    localparam int LAW       = $clog2(POINT_DEPTH);
    localparam int CAP       = (POINT_DEPTH - 1 < 255) ? POINT_DEPTH - 1 : 255;
    localparam int EW        = bibt_pkg::EPOCH_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CHECK,
        ST_ADDR,
        ST_EVAL,
        ST_RDATA,
        ST_FINISH
    } state_t;

    state_t         state_reg, state_next;
    logic [5:0]     row_floor_reg, row_floor_next;
    logic [7:0]     max_points_reg, max_points_next;
    logic [7:0]     edge_min_reg, edge_min_next;
    logic [6:0]     r_reg, r_next;
    logic [6:0]     c_reg, c_next;
    logic [7:0]     n_reg, n_next;
    logic [2:0]     d_reg, d_next;
    logic [2:0]     k_reg, k_next;
    logic [EW-1:0]  epoch_reg, epoch_next;
    logic           clean_reg, clean_next;
    logic [PAW-1:0] clr_reg, clr_next;
    logic [PAW-1:0] addr_reg, addr_next;
    logic           inb_reg, inb_next;
    logic [6:0]     nr_reg, nr_next;
    logic [6:0]     nc_reg, nc_next;
    logic           rd_ok_reg, rd_ok_next;
    logic [7:0]     found_reg, found_next;
    logic           loop_reg, loop_next;
    logic [5:0]     res_row_reg, res_row_next;
    logic [6:0]     res_col_reg, res_col_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_count_reg, out_count_next;
    logic           out_loop_reg, out_loop_next;
    logic [5:0]     out_row_reg, out_row_next;
    logic [6:0]     out_col_reg, out_col_next;

    logic              accept;
    logic [2:0]        dir_i;
    logic signed [7:0] nr_s, nc_s;
    logic              nb_inb;
    logic [PAW-1:0]    nb_addr;
    logic [PAW-1:0]    load_addr;
    logic              load_inside;
    logic              stop;
    logic              vis_hit;
    logic              take;

    logic           pix_we, pix_re, pix_rd;
    logic           vis_we, vis_re;
    logic [PAW-1:0] vis_waddr;
    logic [EW-1:0]  vis_wdata, vis_rd;
    logic           pt_we, pt_re;
    logic [LAW-1:0] pt_waddr;
    logic [12:0]    pt_wdata, pt_rd;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign point_count = out_count_reg;
    assign closed_loop = out_loop_reg;
    assign point_row   = out_row_reg;
    assign point_col   = out_col_reg;

    // Neighbour under test: direction code, coordinates, bounds and address.
    assign dir_i  = d_reg + k_reg;
    assign nr_s   = $signed({1'b0, r_reg}) + bibt_pkg::step_row(dir_i);
    assign nc_s   = $signed({1'b0, c_reg}) + bibt_pkg::step_col(dir_i);
    assign nb_inb = !nr_s[7] && !nc_s[7] && ($unsigned(nr_s) < 8'(IMG_ROWS))
                    && ($unsigned(nc_s) < 8'(IMG_COLS));
    assign nb_addr = PAW'(nr_s[6:0]) * PAW'(IMG_COLS) + PAW'(nc_s[6:0]);

    assign load_inside = ({2'b00, row} < 8'(IMG_ROWS)) && ({1'b0, col} < 8'(IMG_COLS));
    assign load_addr   = PAW'(row) * PAW'(IMG_COLS) + PAW'(col);

    assign stop = (c_reg == 7'd0) || (n_reg > max_points_reg)
                  || (r_reg == {1'b0, row_floor_reg}) || (r_reg == 7'(IMG_ROWS - 1))
                  || ((c_reg == 7'(IMG_COLS - 1)) && (n_reg > edge_min_reg))
                  || (n_reg >= 8'(CAP));

    assign vis_hit = inb_reg && (vis_rd == epoch_reg);
    assign take    = inb_reg && pix_rd;

    // Memory port control.
    assign pix_we    = accept && (func == bibt_pkg::FUNC_LOAD) && load_inside;
    assign pix_re    = (state_reg == ST_ADDR);
    assign vis_re    = (state_reg == ST_ADDR);
    assign vis_we    = (state_reg == ST_CLEAR)
                       || ((state_reg == ST_EVAL) && !(vis_hit && k_reg != 3'd7) && take);
    assign vis_waddr = (state_reg == ST_CLEAR) ? clr_reg : addr_reg;
    assign vis_wdata = (state_reg == ST_CLEAR) ? '0 : epoch_reg;
    assign pt_we     = (accept && (func == bibt_pkg::FUNC_TRACE))
                       || ((state_reg == ST_EVAL) && !(vis_hit && k_reg != 3'd7) && take);
    assign pt_waddr  = (state_reg == ST_EVAL) ? LAW'(n_reg + 8'd1) : '0;
    assign pt_wdata  = (state_reg == ST_EVAL) ? {nr_reg[5:0], nc_reg} : {row, col};
    assign pt_re     = accept && (func == bibt_pkg::FUNC_READ);

    bibt_ram #(.WIDTH(1), .DEPTH(PIX_DEPTH)) u_pixel_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (load_addr),
        .wdata (pixel),
        .re    (pix_re),
        .raddr (nb_addr),
        .rdata (pix_rd)
    );

    bibt_ram #(.WIDTH(EW), .DEPTH(PIX_DEPTH)) u_visited_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (vis_re),
        .raddr (nb_addr),
        .rdata (vis_rd)
    );

    bibt_ram #(.WIDTH(13), .DEPTH(POINT_DEPTH)) u_point_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (LAW'(index)),
        .rdata (pt_rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        row_floor_next  = row_floor_reg;
        max_points_next = max_points_reg;
        edge_min_next   = edge_min_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        k_next          = k_reg;
        epoch_next      = epoch_reg;
        clean_next      = clean_reg;
        clr_next        = clr_reg;
        addr_next       = addr_reg;
        inb_next        = inb_reg;
        nr_next         = nr_reg;
        nc_next         = nc_reg;
        rd_ok_next      = rd_ok_reg;
        found_next      = found_reg;
        loop_next       = loop_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_count_next  = out_count_reg;
        out_loop_next   = out_loop_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (bibt_pkg::reg_index_t'(cfg_index))
                bibt_pkg::REG_ROW_FLOOR:  row_floor_next  = cfg_data[5:0];
                bibt_pkg::REG_MAX_POINTS: max_points_next = cfg_data;
                bibt_pkg::REG_EDGE_MIN:   edge_min_next   = cfg_data;
                default:                  ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_row_next = '0;
                    res_col_next = '0;
                    state_next   = ST_FINISH;
                    case (bibt_pkg::func_t'(func))
                        bibt_pkg::FUNC_TRACE:
                        begin
                            r_next    = {1'b0, row};
                            c_next    = col;
                            n_next    = '0;
                            d_next    = '0;
                            loop_next = 1'b0;
                            if (!clean_reg || (epoch_reg == '1))
                            begin
                                clr_next   = '0;
                                state_next = ST_CLEAR;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + 1'b1;
                                state_next = ST_CHECK;
                            end
                        end
                        bibt_pkg::FUNC_READ:
                        begin
                            rd_ok_next = ({{LAW{1'b0}}, index} < (LAW + 8)'(POINT_DEPTH));
                            state_next = ST_RDATA;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == PAW'(PIX_DEPTH - 1))
                begin
                    clean_next = 1'b1;
                    epoch_next = EW'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                k_next = '0;
                if (stop)
                begin
                    found_next = n_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                addr_next  = nb_addr;
                inb_next   = nb_inb;
                nr_next    = nr_s[6:0];
                nc_next    = nc_s[6:0];
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // A visited neighbour closes the loop, except in the last slot.
                if (vis_hit && (k_reg != 3'd7))
                begin
                    loop_next  = 1'b1;
                    found_next = n_reg;
                    state_next = ST_FINISH;
                end
                else if (take)
                begin
                    n_next     = n_reg + 8'd1;
                    r_next     = nr_reg;
                    c_next     = nc_reg;
                    d_next     = dir_i + 3'd6;
                    state_next = ST_CHECK;
                end
                else if (k_reg == 3'd7)
                begin
                    found_next = n_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_ADDR;
                end
            end
            ST_RDATA:
            begin
                res_row_next = rd_ok_reg ? pt_rd[12:7] : '0;
                res_col_next = rd_ok_reg ? pt_rd[6:0] : '0;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = found_reg;
                    out_loop_next  = loop_reg;
                    out_row_next   = res_row_reg;
                    out_col_next   = res_col_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_floor_reg  <= bibt_pkg::ROW_FLOOR_RST;
            max_points_reg <= bibt_pkg::MAX_POINTS_RST;
            edge_min_reg   <= bibt_pkg::EDGE_MIN_RST;
            n_reg          <= '0;
            epoch_reg      <= '0;
            clean_reg      <= 1'b0;
            found_reg      <= '0;
            loop_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_floor_reg  <= row_floor_next;
            max_points_reg <= max_points_next;
            edge_min_reg   <= edge_min_next;
            n_reg          <= n_next;
            epoch_reg      <= epoch_next;
            clean_reg      <= clean_next;
            found_reg      <= found_next;
            loop_reg       <= loop_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg         <= r_next;
        c_reg         <= c_next;
        d_reg         <= d_next;
        k_reg         <= k_next;
        clr_reg       <= clr_next;
        addr_reg      <= addr_next;
        inb_reg       <= inb_next;
        nr_reg        <= nr_next;
        nc_reg        <= nc_next;
        rd_ok_reg     <= rd_ok_next;
        res_row_reg   <= res_row_next;
        res_col_reg   <= res_col_next;
        out_count_reg <= out_count_next;
        out_loop_reg  <= out_loop_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
    end

    // The walk only runs once the visited memory has been swept clean.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK || state_reg == ST_ADDR || state_reg == ST_EVAL)
        |-> (clean_reg && (epoch_reg != '0)))
        else $error("trace walk running without a clean visited map");

    // A new result is only loaded from the finishing step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result offered outside the finishing step");

    // The point count never passes the list capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= 8'(CAP))
        else $error("point count beyond list capacity");

    // Appended points always lie inside the image.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && take) |-> inb_reg)
        else $error("out of bounds neighbour taken");

endmodule
